[sv/swrl_pkg.sv]
// Shared types and constants for the sliding-window reply limiter.
// Used by swrl_cfg and sliding_window_reply_limiter; depends on nothing.
package swrl_pkg;

  localparam int LOG_CAPACITY = 255;
  localparam int IDX_W = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;
  localparam int CNT_W = $clog2(LOG_CAPACITY + 1);
  localparam int SAT_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int ADDR_W = 4;

  localparam logic [31:0] WINDOW_RST    = 32'd300000;
  localparam logic [7:0]  THRESHOLD_RST = 8'd20;
  localparam logic [31:0] COOLDOWN_RST  = 32'd5000;
  localparam logic [15:0] PAUSE_RST     = 16'd300;

  typedef enum logic [1:0] {
    REG_WINDOW    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_COOLDOWN  = 2'd2,
    REG_PAUSE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] window_ms;
    logic [7:0]  quiet_threshold;
    logic [31:0] cooldown_ms;
    logic [15:0] reply_pause_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

[sv/swrl_cfg.sv]
// APB-style register file for the limiter settings.
// Depends on swrl_pkg (cfg_t, reg_idx_t, reset values).
module swrl_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output swrl_pkg::cfg_t             cfg
);
  import swrl_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms       <= WINDOW_RST;
      cfg.quiet_threshold <= THRESHOLD_RST;
      cfg.cooldown_ms     <= COOLDOWN_RST;
      cfg.reply_pause_ms  <= PAUSE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_WINDOW:    cfg.window_ms       <= pwdata;
        REG_THRESHOLD: cfg.quiet_threshold <= pwdata[7:0];
        REG_COOLDOWN:  cfg.cooldown_ms     <= pwdata;
        REG_PAUSE:     cfg.reply_pause_ms  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW:    prdata = cfg.window_ms;
      REG_THRESHOLD: prdata = {24'd0, cfg.quiet_threshold};
      REG_COOLDOWN:  prdata = cfg.cooldown_ms;
      REG_PAUSE:     prdata = {16'd0, cfg.reply_pause_ms};
    endcase
  end

endmodule

[sv/sliding_window_reply_limiter.sv]
// Sliding-window reply limiter: arrival log in a one-port-each RAM, compaction walk,
// reply decision and counters. Depends on swrl_pkg and swrl_cfg.
//
//   channel | signals                                         | direction
//   input   | in_valid, in_ready, now_ms, reply_wanted        | in
//   result  | out_valid, out_ready, send_reply, quiet_flag,   | out
//           | recent_count, replies_sent, replies_refused     |
//   config  | psel, penable, pwrite, paddr, pwdata, prdata,   | in/out
//           | pready                                          |
//
// An arrival walks the L log entries held before it (at most 255), one log RAM read
// per cycle, then finishes; with an empty log the walk is skipped. A new arrival is
// accepted only after the previous one has finished its final step.
// Reset needs no clearing pass; only entries below the log count are ever read.
// The result register frees the input side; a held result stalls only the final
// step of the following transaction.
module sliding_window_reply_limiter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 now_ms,
  input  logic                        reply_wanted,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        send_reply,
  output logic                        quiet_flag,
  output logic [7:0]                  recent_count,
  output logic [31:0]                 replies_sent,
  output logic [31:0]                 replies_refused,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import swrl_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;

  logic [31:0]      log_mem [LOG_CAPACITY];
  logic [31:0]      rd_data;
  logic             we;
  logic [31:0]      wdata;

  logic [31:0]      now_q;
  logic             wanted_q;
  logic             cool_ok;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] kept;
  logic             pend;
  logic [CNT_W-1:0] log_count;
  logic [31:0]      last_reply_time;
  logic [31:0]      sent_total;
  logic [31:0]      refused_total;

  logic             accept;
  logic             issue;
  logic             keep;
  logic             fin_go;
  logic             room;
  logic [CNT_W-1:0] count_next;
  logic [SAT_W-1:0] count_sat;
  logic             quiet;
  logic             send;

  swrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // FSM next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = (log_count == '0) ? S_FINISH : S_SCAN;
      S_SCAN:   if (!issue) state_next = S_FINISH;
      S_FINISH: if (fin_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    fin_go   = 1'b0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_SCAN:   issue    = (rd_idx < limit);
      S_FINISH: fin_go   = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  assign accept     = in_valid & in_ready;
  assign keep       = pend && ((now_q - rd_data) < cfg.window_ms);
  assign room       = (kept < CNT_W'(LOG_CAPACITY));
  assign count_next = room ? kept + CNT_W'(1) : kept;
  assign count_sat  = SAT_W'(count_next);
  assign quiet      = count_sat >= SAT_W'(cfg.quiet_threshold);
  assign send       = wanted_q && !quiet && cool_ok;

  // compaction writes survivors down to kept; the final step appends now_q at kept when there is room
  assign we    = keep || (fin_go && room);
  assign wdata = fin_go ? now_q : rd_data;

  always_ff @(posedge clk) begin
    if (we) log_mem[kept[IDX_W-1:0]] <= wdata;
    if (issue) rd_data <= log_mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pend            <= 1'b0;
      log_count       <= '0;
      last_reply_time <= '0;
      sent_total      <= '0;
      refused_total   <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (fin_go) begin
        log_count <= count_next;
        if (send) begin
          last_reply_time <= now_q + {16'd0, cfg.reply_pause_ms};
          sent_total      <= sent_total + 32'd1;
        end else if (wanted_q) begin
          refused_total <= refused_total + 32'd1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q    <= now_ms;
      wanted_q <= reply_wanted;
      cool_ok  <= (now_ms - last_reply_time) > cfg.cooldown_ms;
      limit    <= log_count;
      rd_idx   <= '0;
      kept     <= '0;
    end else begin
      if (issue) rd_idx <= rd_idx + CNT_W'(1);
      if (keep) kept <= kept + CNT_W'(1);
    end
    if (fin_go) begin
      send_reply      <= send;
      quiet_flag      <= quiet;
      recent_count    <= (count_sat > SAT_W'(255)) ? 8'd255 : count_sat[7:0];
      replies_sent    <= send ? sent_total + 32'd1 : sent_total;
      replies_refused <= (wanted_q && !send) ? refused_total + 32'd1 : refused_total;
    end
  end

`ifndef SYNTHESIS
  a_log_bound: assert property (@(posedge clk) disable iff (rst)
    log_count <= CNT_W'(LOG_CAPACITY))
    else $error("log count above capacity");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> (kept < rd_idx))
    else $error("compaction write overtook the read pointer");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> out_valid)
    else $error("finished transaction produced no result");

  a_no_send_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(send_reply && quiet_flag))
    else $error("reply allowed while quiet");
`endif

endmodule

[test/tb_sliding_window_reply_limiter.sv]
// Testbench for sliding_window_reply_limiter: directed and random arrival traffic, APB
// register writes with readback, and a cycle-free behavioral model that checks every result.
// Depends on swrl_pkg and the limiter RTL.
module tb_sliding_window_reply_limiter;
  import swrl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic        send;
    logic        quiet;
    logic [7:0]  count;
    logic [31:0] sent;
    logic [31:0] refused;
  } reply_decision_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [31:0]       now_ms;
  logic              reply_wanted;
  logic              out_valid;
  logic              out_ready;
  logic              send_reply;
  logic              quiet_flag;
  logic [7:0]        recent_count;
  logic [31:0]       replies_sent;
  logic [31:0]       replies_refused;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  sliding_window_reply_limiter u_dut (.*);

  // limiter model state
  logic [31:0] arrival_times[$];
  logic [31:0] win_cfg;
  logic [7:0]  thr_cfg;
  logic [31:0] cool_cfg;
  logic [15:0] pause_cfg;
  logic [31:0] last_reply_at;
  logic [31:0] sent_count;
  logic [31:0] refused_count;
  reply_decision_t expected_decisions[$];

  int failures;
  int arrivals_sent;
  int results_checked;
  int replies_allowed;
  int quiet_results;
  int peak_count;
  int idle_cycles;
  bit steady;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic reply_decision_t decide_reply(logic [31:0] at, logic wanted);
    reply_decision_t d;
    logic [31:0] kept[$];
    logic [31:0] since;
    foreach (arrival_times[i]) begin
      if (32'(at - arrival_times[i]) < win_cfg) kept.push_back(arrival_times[i]);
    end
    arrival_times = kept;
    if (arrival_times.size() < LOG_CAPACITY) arrival_times.push_back(at);
    d.quiet = (arrival_times.size() >= int'(thr_cfg));
    d.send = 1'b0;
    since = at - last_reply_at;
    if (wanted) begin
      if (!d.quiet && since > cool_cfg) begin
        d.send = 1'b1;
        last_reply_at = at + 32'(pause_cfg);
        sent_count = sent_count + 32'd1;
      end else begin
        refused_count = refused_count + 32'd1;
      end
    end
    d.count = (arrival_times.size() > 255) ? 8'd255 : 8'(arrival_times.size());
    d.sent = sent_count;
    d.refused = refused_count;
    return d;
  endfunction

  always @(posedge clk) begin : check_results
    reply_decision_t want_d;
    if (!rst) begin
      if (in_valid && in_ready) expected_decisions.push_back(decide_reply(now_ms, reply_wanted));
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          $error("result transaction with no pending arrival");
          failures++;
        end else begin
          want_d = expected_decisions.pop_front();
          results_checked++;
          if (want_d.send) replies_allowed++;
          if (want_d.quiet) quiet_results++;
          if (int'(want_d.count) > peak_count) peak_count = int'(want_d.count);
          if (send_reply !== want_d.send) begin
            $error("send_reply: expected %0d, got %0d", want_d.send, send_reply);
            failures++;
          end
          if (quiet_flag !== want_d.quiet) begin
            $error("quiet_flag: expected %0d, got %0d", want_d.quiet, quiet_flag);
            failures++;
          end
          if (recent_count !== want_d.count) begin
            $error("recent_count: expected %0d, got %0d", want_d.count, recent_count);
            failures++;
          end
          if (replies_sent !== want_d.sent) begin
            $error("replies_sent: expected %0d, got %0d", want_d.sent, replies_sent);
            failures++;
          end
          if (replies_refused !== want_d.refused) begin
            $error("replies_refused: expected %0d, got %0d", want_d.refused, replies_refused);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result-side backpressure
  initial begin : drive_out_ready
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_ready <= !out_ready;
        hold = pick_gap();
      end
    end
  end

  task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    logic [31:0] unused;
    apb_access(idx, 1'b1, data, unused);
    case (idx)
      REG_WINDOW:    win_cfg = data;
      REG_THRESHOLD: thr_cfg = data[7:0];
      REG_COOLDOWN:  cool_cfg = data;
      REG_PAUSE:     pause_cfg = data[15:0];
    endcase
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] rd;
    logic [31:0] want;
    case (idx)
      REG_WINDOW:    want = win_cfg;
      REG_THRESHOLD: want = {24'd0, thr_cfg};
      REG_COOLDOWN:  want = cool_cfg;
      default:       want = {16'd0, pause_cfg};
    endcase
    apb_access(idx, 1'b0, $urandom, rd);
    if (rd !== want) begin
      $error("prdata[%s]: expected %0d, got %0d", idx.name(), want, rd);
      failures++;
    end
  endtask

  task automatic check_all_regs();
    check_reg(REG_WINDOW);
    check_reg(REG_THRESHOLD);
    check_reg(REG_COOLDOWN);
    check_reg(REG_PAUSE);
  endtask

  // unused upper bits carry random junk that the block must drop
  task automatic set_limits(input logic [31:0] win, input logic [7:0] thr,
                            input logic [31:0] cool, input logic [15:0] pause);
    write_reg(REG_WINDOW, win);
    write_reg(REG_THRESHOLD, ($urandom & 32'hFFFF_FF00) | {24'd0, thr});
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_PAUSE, ($urandom & 32'hFFFF_0000) | {16'd0, pause});
    check_all_regs();
  endtask

  task automatic send_arrival(input logic [31:0] at, input logic wanted);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= at;
    reply_wanted <= wanted;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    arrivals_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    check_all_regs();
    send_arrival(32'd0, 1'b1);
    send_arrival(32'd6000, 1'b1);
    send_arrival(32'd6100, 1'b0);
    send_arrival(32'd6200, 1'b1);
    send_arrival(32'd11301, 1'b1);
    send_arrival(32'd400000, 1'b1);
  endtask

  task automatic test_field_extremes();
    settle();
    set_limits(32'd300000, 8'd3, 32'd0, 16'hFFFF);
    send_arrival(32'hFFFF_FFFF, 1'b1);
    send_arrival(32'h0000_0000, 1'b1);
    send_arrival(32'h7FFF_FFFF, 1'b1);
    send_arrival(32'h8000_0000, 1'b0);
    send_arrival(32'h8000_0000, 1'b1);
    send_arrival(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_window_zero();
    settle();
    set_limits(32'd0, 8'd3, 32'd0, 16'd0);
    send_arrival(32'd5, 1'b1);
    send_arrival(32'd5, 1'b1);
    send_arrival(32'd1000, 1'b1);
  endtask

  task automatic test_threshold_zero();
    settle();
    set_limits(32'd1000, 8'd0, 32'd0, 16'd0);
    send_arrival(32'd2000, 1'b1);
    send_arrival(32'd9000, 1'b1);
    send_arrival(32'd9001, 1'b0);
    send_arrival(32'd50000, 1'b1);
  endtask

  task automatic test_register_extremes();
    settle();
    set_limits(32'd1, 8'd255, 32'hFFFF_FFFF, 16'd0);
    send_arrival(32'd100, 1'b1);
    send_arrival(32'd100, 1'b1);
    send_arrival(32'd100, 1'b1);
    send_arrival(32'd101, 1'b1);
    settle();
    set_limits(32'hFFFF_FFFF, 8'd1, 32'd0, 16'hFFFF);
    send_arrival(32'd200, 1'b1);
    send_arrival(32'd0, 1'b1);
  endtask

  task automatic test_log_full(input int n);
    settle();
    set_limits(32'hFFFF_FFFF, 8'd255, $urandom_range(0, 500), 16'($urandom_range(0, 300)));
    clock_ms = $urandom;
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(0, 1000);
      send_arrival(clock_ms, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [31:0] win;
    logic [31:0] span;
    logic [31:0] cool;
    logic [7:0]  thr;
    logic [15:0] pause;
    int r;
    for (int p = 0; p < phases; p++) begin
      settle();
      r = $urandom_range(0, 9);
      if (r < 3) win = $urandom_range(1, 64);
      else if (r < 7) win = $urandom_range(1000, 400000);
      else if (r < 9) win = $urandom;
      else win = 32'hFFFF_FFFF;
      span = (win < 16) ? 32'd3 : win / 16;
      r = $urandom_range(0, 9);
      if (r == 0) thr = 8'd255;
      else if (r == 1) thr = 8'd1;
      else thr = 8'($urandom_range(2, 40));
      cool = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom % (span + 1)) * 2;
      pause = $urandom_range(0, 1) ? 16'($urandom % (span + 1)) : 16'($urandom);
      steady = ($urandom_range(0, 3) == 0);
      set_limits(win, thr, cool, pause);
      for (int k = 0; k < per_phase; k++) begin
        if ((p == 0 && k == per_phase / 2) || $urandom_range(0, 59) == 0) settle();
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
        else clock_ms += $urandom % (span + 1);
        send_arrival(clock_ms, $urandom_range(0, 3) != 0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    reply_wanted = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    failures = 0;
    arrivals_sent = 0;
    results_checked = 0;
    replies_allowed = 0;
    quiet_results = 0;
    peak_count = 0;
    idle_cycles = 0;
    clock_ms = '0;
    win_cfg = WINDOW_RST;
    thr_cfg = THRESHOLD_RST;
    cool_cfg = COOLDOWN_RST;
    pause_cfg = PAUSE_RST;
    last_reply_at = '0;
    sent_count = '0;
    refused_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_window_zero();
    test_threshold_zero();
    test_register_extremes();
    test_log_full(270);
    test_random_traffic(10, 105);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d arrivals, %0d results checked: %0d replies allowed, %0d quiet",
             arrivals_sent, results_checked, replies_allowed, quiet_results);
    $display("peak log occupancy %0d of %0d, window/threshold/cooldown/pause swept",
             peak_count, LOG_CAPACITY);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sliding_window_reply_limiter.f]
sv/swrl_pkg.sv
sv/swrl_cfg.sv
sv/sliding_window_reply_limiter.sv
test/tb_sliding_window_reply_limiter.sv
